@@ hw/rtl/rvl_pkg.sv @@
`timescale 1ns / 1ps
// rvl_pkg: shared widths, register indexes, reset values and bundle types
// for the radial vignette luma block. No dependencies.

package rvl_pkg;

  // payload and register widths
  localparam int PIX_W      = 8;
  localparam int POS_W      = 12;
  localparam int DIM_W      = 13;
  localparam int RAD_W      = 16;
  localparam int GAIN_W     = 24;
  localparam int GAIN_FRAC  = 16;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  // offset from center fits in 12 bits since a clamped size stays below 8192
  localparam int DELTA_W = 12;
  localparam int SUM_W   = 2 * DELTA_W + 1;

  // register reset values
  localparam logic [DIM_W-1:0]  WIDTH_RST  = DIM_W'(640);
  localparam logic [DIM_W-1:0]  HEIGHT_RST = DIM_W'(480);
  localparam logic [RAD_W-1:0]  START_RST  = '0;
  localparam logic [GAIN_W-1:0] GAIN_RST   = '0;

  // register indexes on the config port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 8'd0,
    REG_IMAGE_HEIGHT = 8'd1,
    REG_START_RADIUS = 8'd2,
    REG_RAMP_GAIN    = 8'd3
  } cfg_reg_t;

  // current register set, handed to the datapath
  typedef struct packed {
    logic [DIM_W-1:0]  width;
    logic [DIM_W-1:0]  height;
    logic [RAD_W-1:0]  start;
    logic [GAIN_W-1:0] gain;
  } cfg_t;

  // data that rides along the root chain
  typedef struct packed {
    logic             darken;
    logic [PIX_W-1:0] pix;
  } side_t;

endpackage

@@ hw/rtl/rvl_if.sv @@
`timescale 1ns / 1ps
// rvl_if: valid/ready channel interfaces for pixel input, pixel output and
// register writes. Depends on rvl_pkg.

interface rvl_pix_in_if;
  logic                       valid;
  logic                       ready;
  logic [rvl_pkg::PIX_W-1:0]  pixel_in;
  logic [rvl_pkg::POS_W-1:0]  column;
  logic [rvl_pkg::POS_W-1:0]  row_index;

  modport source (output valid, pixel_in, column, row_index, input ready);
  modport sink   (input valid, pixel_in, column, row_index, output ready);
endinterface

interface rvl_pix_out_if;
  logic                      valid;
  logic                      ready;
  logic [rvl_pkg::PIX_W-1:0] pixel_out;

  modport source (output valid, pixel_out, input ready);
  modport sink   (input valid, pixel_out, output ready);
endinterface

interface rvl_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [rvl_pkg::CFG_IDX_W-1:0]  index;
  logic [rvl_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ hw/rtl/rvl_front.sv @@
`timescale 1ns / 1ps
// rvl_front: folds the pixel position into the top-left quadrant, forms the
// offsets from center and the squared distance. Depends on rvl_pkg.

module rvl_front #(
  parameter int MAX_DIM   = 4096,
  parameter int FRAC_BITS = 4,
  parameter int ROOT_W    = 17
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        vld_i,
  input  logic [rvl_pkg::PIX_W-1:0]   pix_i,
  input  logic [rvl_pkg::POS_W-1:0]   col_i,
  input  logic [rvl_pkg::POS_W-1:0]   row_i,
  input  rvl_pkg::cfg_t               cfg_i,
  output logic                        vld_o,
  output logic [2*ROOT_W-1:0]         rad_o,
  output rvl_pkg::side_t              side_o
);

  localparam int DIM_W   = rvl_pkg::DIM_W;
  localparam int DELTA_W = rvl_pkg::DELTA_W;
  localparam int SUM_W   = rvl_pkg::SUM_W;
  localparam int RADW    = 2 * ROOT_W;
  localparam logic [31:0] MAX_L = 32'(MAX_DIM);

  logic [DIM_W-1:0]   w, h, x, y, rx, ry, qx, qy, cx, cy, ddx, ddy;
  logic               in_frame, mid_ok;

  logic               s1_vld_r, s1_vld_nxt;
  logic [DELTA_W-1:0] s1_dx_r, s1_dy_r;
  rvl_pkg::side_t     s1_side_r, s1_side_nxt;

  logic [2*DELTA_W-1:0] dxx, dyy;
  logic [SUM_W-1:0]     sum;
  logic                 s2_vld_r;
  logic [RADW-1:0]      s2_rad_r;
  rvl_pkg::side_t       s2_side_r;

  // clamp frame size and fold position
  always_comb begin
    w   = ({19'b0, cfg_i.width}  > MAX_L) ? DIM_W'(MAX_DIM) : cfg_i.width;
    h   = ({19'b0, cfg_i.height} > MAX_L) ? DIM_W'(MAX_DIM) : cfg_i.height;
    x   = {1'b0, col_i};
    y   = {1'b0, row_i};
    in_frame = (x < w) && (y < h);
    rx  = w - DIM_W'(1) - x;
    ry  = h - DIM_W'(1) - y;
    qx  = (rx < x) ? rx : x;
    qy  = (ry < y) ? ry : y;
    cx  = w >> 1;
    cy  = h >> 1;
    mid_ok = (qx < cx) && (qy < cy);
    ddx = cx - qx;
    ddy = cy - qy;
    s1_vld_nxt         = vld_i;
    s1_side_nxt.darken = in_frame && mid_ok;
    s1_side_nxt.pix    = pix_i;
  end

  // stage 1 registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
    end
    s1_dx_r   <= ddx[DELTA_W-1:0];
    s1_dy_r   <= ddy[DELTA_W-1:0];
    s1_side_r <= s1_side_nxt;
  end

  // squared distance, scaled for the fraction bits of the root
  assign dxx = s1_dx_r * s1_dx_r;
  assign dyy = s1_dy_r * s1_dy_r;
  assign sum = SUM_W'(dxx) + SUM_W'(dyy);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
    s2_rad_r  <= RADW'(sum) << (2 * FRAC_BITS);
    s2_side_r <= s1_side_r;
  end

  assign vld_o  = s2_vld_r;
  assign rad_o  = s2_rad_r;
  assign side_o = s2_side_r;

endmodule

@@ hw/rtl/rvl_root_cell.sv @@
`timescale 1ns / 1ps
// rvl_root_cell: one digit step of the restoring square root; takes two
// radicand bits, decides one root bit and passes all on. Depends on rvl_pkg.

module rvl_root_cell #(
  parameter int ROOT_W = 17
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 vld_i,
  input  logic [2*ROOT_W-1:0]  rad_i,
  input  logic [ROOT_W-1:0]    root_i,
  input  logic [ROOT_W:0]      rem_i,
  input  rvl_pkg::side_t       side_i,
  output logic                 vld_o,
  output logic [2*ROOT_W-1:0]  rad_o,
  output logic [ROOT_W-1:0]    root_o,
  output logic [ROOT_W:0]      rem_o,
  output rvl_pkg::side_t       side_o
);

  logic [ROOT_W+2:0]   cur, trial, diff;
  logic                take;

  logic                vld_r;
  logic [2*ROOT_W-1:0] rad_r, rad_nxt;
  logic [ROOT_W-1:0]   root_r, root_nxt;
  logic [ROOT_W:0]     rem_r, rem_nxt;
  rvl_pkg::side_t      side_r;

  // trial subtract of 4*root+1 from the extended remainder
  always_comb begin
    cur      = {rem_i, rad_i[2*ROOT_W-1 -: 2]};
    trial    = {1'b0, root_i, 2'b01};
    diff     = cur - trial;
    take     = (cur >= trial);
    rem_nxt  = take ? diff[ROOT_W:0] : cur[ROOT_W:0];
    root_nxt = {root_i[ROOT_W-2:0], take};
    rad_nxt  = rad_i << 2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
    rad_r  <= rad_nxt;
    root_r <= root_nxt;
    rem_r  <= rem_nxt;
    side_r <= side_i;
  end

  assign vld_o  = vld_r;
  assign rad_o  = rad_r;
  assign root_o = root_r;
  assign rem_o  = rem_r;
  assign side_o = side_r;

endmodule

@@ hw/rtl/rvl_ramp.sv @@
`timescale 1ns / 1ps
// rvl_ramp: distance past the start radius, times the gain, clamped and
// taken off the luma byte. Depends on rvl_pkg.

module rvl_ramp #(
  parameter int ROOT_W    = 17,
  parameter int FRAC_BITS = 4
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         vld_i,
  input  logic [ROOT_W-1:0]            dist_i,
  input  rvl_pkg::side_t               side_i,
  input  logic [rvl_pkg::RAD_W-1:0]    start_i,
  input  logic [rvl_pkg::GAIN_W-1:0]   gain_i,
  output logic                         vld_o,
  output logic [rvl_pkg::PIX_W-1:0]    pix_o
);

  localparam int PIX_W  = rvl_pkg::PIX_W;
  localparam int DIFF_W = (ROOT_W > rvl_pkg::RAD_W) ? ROOT_W : rvl_pkg::RAD_W;
  localparam int PROD_W = DIFF_W + rvl_pkg::GAIN_W;
  localparam int SHIFT  = FRAC_BITS + rvl_pkg::GAIN_FRAC;

  logic [DIFF_W-1:0] dist_x, start_x;

  logic              a_vld_r, a_apply_r;
  logic [PIX_W-1:0]  a_pix_r;
  logic [DIFF_W-1:0] a_diff_r;

  logic              b_vld_r, b_apply_r;
  logic [PIX_W-1:0]  b_pix_r;
  logic [PROD_W-1:0] b_prod_r;

  logic [PROD_W-1:0] amt_full;
  logic [PIX_W-1:0]  amt;

  assign dist_x  = DIFF_W'(dist_i);
  assign start_x = DIFF_W'(start_i);

  // compare against start radius
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else begin
      a_vld_r <= vld_i;
    end
    a_apply_r <= side_i.darken && (dist_x >= start_x);
    a_pix_r   <= side_i.pix;
    a_diff_r  <= dist_x - start_x;
  end

  // scale by the ramp gain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else begin
      b_vld_r <= a_vld_r;
    end
    b_apply_r <= a_apply_r;
    b_pix_r   <= a_pix_r;
    b_prod_r  <= PROD_W'(a_diff_r) * PROD_W'(gain_i);
  end

  // clamp amount and saturate at zero
  always_comb begin
    amt_full = b_prod_r >> SHIFT;
    amt      = (|amt_full[PROD_W-1:PIX_W]) ? {PIX_W{1'b1}} : amt_full[PIX_W-1:0];
    if (!b_apply_r) begin
      pix_o = b_pix_r;
    end else if (amt > b_pix_r) begin
      pix_o = '0;
    end else begin
      pix_o = b_pix_r - amt;
    end
  end

  assign vld_o = b_vld_r;

endmodule

@@ hw/rtl/rvl_out_fifo.sv @@
`timescale 1ns / 1ps
// rvl_out_fifo: result queue between the free-running datapath and the
// output channel. Depends on rvl_pkg.

module rvl_out_fifo #(
  parameter int DEPTH = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      wr_en,
  input  logic [rvl_pkg::PIX_W-1:0] wr_data,
  input  logic                      rd_en,
  output logic                      rd_valid,
  output logic [rvl_pkg::PIX_W-1:0] rd_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int FW = $clog2(DEPTH + 1);

  logic [rvl_pkg::PIX_W-1:0] mem_r [0:DEPTH-1];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [FW-1:0] fill_r, fill_nxt;
  logic          pop;

  assign pop      = rd_en && (fill_r != '0);
  assign fill_nxt = fill_r + FW'(wr_en) - FW'(pop);

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= wr_ptr_r + AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + AW'(1);
      end
      fill_r <= fill_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  assign rd_valid = (fill_r != '0);
  assign rd_data  = mem_r[rd_ptr_r];

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (fill_r != FW'(DEPTH)) || rd_en)
    else $error("result queue overflow");

endmodule

@@ hw/rtl/radial_vignette_luma.sv @@
`timescale 1ns / 1ps
// radial_vignette_luma: top level; register file, position fold, square
// root cell chain, ramp and result queue. Depends on rvl_pkg and rvl_if.
//
// Usage:
//   in_chan  carries one luma beat with its column and row; out_chan returns
//   one darkened luma beat per input beat, in order. cfg_chan writes the
//   size, start radius and gain registers (index 0..3, unknown indexes are
//   dropped); it is always ready and should be used only while the block is
//   empty.
// Timing:
//   Each beat passes the front stages, the square root cell chain, whose
//   length is ROOT_W = 13 + FRAC_BITS, the ramp stages and the result queue.
//   One beat per cycle is sustained while out_chan is ready: the
//   datapath never stalls and a result queue of DEPTH entries absorbs it.
// Reset:
//   rst_n (synchronous) empties the pipeline and queue and loads the
//   register defaults (640 x 480, start 0, gain 0).
// Stall:
//   while out_chan is held, results pile up in the queue; in_chan.ready
//   drops only once DEPTH beats are in flight or waiting.

module radial_vignette_luma #(
  parameter int MAX_DIM   = 4096,
  parameter int FRAC_BITS = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  rvl_pix_in_if.sink           in_chan,
  rvl_pix_out_if.source        out_chan,
  rvl_cfg_if.sink              cfg_chan
);

  localparam int ROOT_W = rvl_pkg::DELTA_W + 1 + FRAC_BITS;
  localparam int LAT    = ROOT_W + 5;
  localparam int DEPTH  = 2 ** $clog2(LAT + 2);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int PIX_W  = rvl_pkg::PIX_W;

  rvl_pkg::cfg_t     cfg_r;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              in_acc, out_acc;

  logic                fr_vld;
  logic [2*ROOT_W-1:0] fr_rad;
  rvl_pkg::side_t      fr_side;

  logic                vld_c  [0:ROOT_W];
  logic [2*ROOT_W-1:0] rad_c  [0:ROOT_W];
  logic [ROOT_W-1:0]   root_c [0:ROOT_W];
  logic [ROOT_W:0]     rem_c  [0:ROOT_W];
  rvl_pkg::side_t      side_c [0:ROOT_W];

  logic              res_vld;
  logic [PIX_W-1:0]  res_pix;

  // register writes
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.width  <= rvl_pkg::WIDTH_RST;
      cfg_r.height <= rvl_pkg::HEIGHT_RST;
      cfg_r.start  <= rvl_pkg::START_RST;
      cfg_r.gain   <= rvl_pkg::GAIN_RST;
    end else if (cfg_chan.valid) begin
      case (cfg_chan.index)
        rvl_pkg::REG_IMAGE_WIDTH:  cfg_r.width  <= cfg_chan.data[rvl_pkg::DIM_W-1:0];
        rvl_pkg::REG_IMAGE_HEIGHT: cfg_r.height <= cfg_chan.data[rvl_pkg::DIM_W-1:0];
        rvl_pkg::REG_START_RADIUS: cfg_r.start  <= cfg_chan.data[rvl_pkg::RAD_W-1:0];
        rvl_pkg::REG_RAMP_GAIN:    cfg_r.gain   <= cfg_chan.data[rvl_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // credit count of beats in flight or queued
  assign in_acc         = in_chan.valid && in_chan.ready;
  assign out_acc        = out_chan.valid && out_chan.ready;
  assign in_chan.ready  = (cnt_r < CNT_W'(DEPTH));
  assign cnt_nxt        = cnt_r + CNT_W'(in_acc) - CNT_W'(out_acc);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // fold and square
  rvl_front #(
    .MAX_DIM   (MAX_DIM),
    .FRAC_BITS (FRAC_BITS),
    .ROOT_W    (ROOT_W)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_i  (in_acc),
    .pix_i  (in_chan.pixel_in),
    .col_i  (in_chan.column),
    .row_i  (in_chan.row_index),
    .cfg_i  (cfg_r),
    .vld_o  (fr_vld),
    .rad_o  (fr_rad),
    .side_o (fr_side)
  );

  // square root chain, one root bit per cell
  assign vld_c[0]  = fr_vld;
  assign rad_c[0]  = fr_rad;
  assign root_c[0] = '0;
  assign rem_c[0]  = '0;
  assign side_c[0] = fr_side;

  for (genvar k = 0; k < ROOT_W; k++) begin : g_root
    rvl_root_cell #(
      .ROOT_W (ROOT_W)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .vld_i  (vld_c[k]),
      .rad_i  (rad_c[k]),
      .root_i (root_c[k]),
      .rem_i  (rem_c[k]),
      .side_i (side_c[k]),
      .vld_o  (vld_c[k+1]),
      .rad_o  (rad_c[k+1]),
      .root_o (root_c[k+1]),
      .rem_o  (rem_c[k+1]),
      .side_o (side_c[k+1])
    );
  end

  // falloff ramp
  rvl_ramp #(
    .ROOT_W    (ROOT_W),
    .FRAC_BITS (FRAC_BITS)
  ) u_ramp (
    .clk     (clk),
    .rst_n   (rst_n),
    .vld_i   (vld_c[ROOT_W]),
    .dist_i  (root_c[ROOT_W]),
    .side_i  (side_c[ROOT_W]),
    .start_i (cfg_r.start),
    .gain_i  (cfg_r.gain),
    .vld_o   (res_vld),
    .pix_o   (res_pix)
  );

  // result queue
  rvl_out_fifo #(
    .DEPTH (DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (res_vld),
    .wr_data  (res_pix),
    .rd_en    (out_chan.ready),
    .rd_valid (out_chan.valid),
    .rd_data  (out_chan.pixel_out)
  );

  // checks
  a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("credit count above queue depth");

  a_out_has_credit: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> (cnt_r != '0))
    else $error("result shown with no beat in flight");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> ##(ROOT_W + 4) res_vld)
    else $error("beat lost in datapath");

  a_root_rem: assert property (@(posedge clk) disable iff (!rst_n)
    vld_c[ROOT_W] |-> (rem_c[ROOT_W] <= {root_c[ROOT_W], 1'b0}))
    else $error("square root remainder too large");

  a_rad_drained: assert property (@(posedge clk) disable iff (!rst_n)
    vld_c[ROOT_W] |-> (rad_c[ROOT_W] == '0))
    else $error("radicand bits left after root chain");

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// testbench: streams luma beats under changing register settings through
// radial_vignette_luma and checks each result against a behavioral predictor.
// Depends on rvl_pkg, rvl_if and the radial_vignette_luma top level.

module testbench;

  localparam int MAX_DIM     = 4096;
  localparam int FRAC_BITS   = 4;
  localparam int HOLD_LEN    = 400;
  localparam int TAIL_CYCLES = 40;
  localparam int RAND_PHASES = 10;
  localparam int HOLD_PHASE  = 8;

  localparam int PIX_W      = rvl_pkg::PIX_W;
  localparam int POS_W      = rvl_pkg::POS_W;
  localparam int DIM_W      = rvl_pkg::DIM_W;
  localparam int RAD_W      = rvl_pkg::RAD_W;
  localparam int GAIN_W     = rvl_pkg::GAIN_W;
  localparam int GAIN_FRAC  = rvl_pkg::GAIN_FRAC;
  localparam int CFG_IDX_W  = rvl_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = rvl_pkg::CFG_DATA_W;

  // an index the register file does not decode
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = CFG_IDX_W'(9);

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] row;
  } luma_beat_t;

  logic clk = 1'b0;
  logic rst_n;

  rvl_pix_in_if  in_chan ();
  rvl_pix_out_if out_chan ();
  rvl_cfg_if     cfg_chan ();

  radial_vignette_luma #(
    .MAX_DIM   (MAX_DIM),
    .FRAC_BITS (FRAC_BITS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  // predictor copy of the register file
  logic [DIM_W-1:0]  vig_width  = rvl_pkg::WIDTH_RST;
  logic [DIM_W-1:0]  vig_height = rvl_pkg::HEIGHT_RST;
  logic [RAD_W-1:0]  vig_start  = rvl_pkg::START_RST;
  logic [GAIN_W-1:0] vig_gain   = rvl_pkg::GAIN_RST;

  luma_beat_t       pending_beats[$];
  logic [PIX_W-1:0] expected_luma[$];
  logic [PIX_W-1:0] want_luma;
  logic             offering;
  int               mismatches = 0;
  int               send_idle_pct = 0;
  int               recv_idle_pct = 0;
  int               hold_requests = 0;
  int               holds_served;
  int               hold_cycles;

  // clock, 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // floor of the square root, one result bit per step from the top
  function automatic logic [63:0] floor_root(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] trial;
    r = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = r | (64'd1 << b);
      if (trial * trial <= v) r = trial;
    end
    return r;
  endfunction

  // expected luma for one beat under the current register copy
  function automatic logic [PIX_W-1:0] darken_luma(luma_beat_t b);
    logic [63:0] w, h, qx, qy, cx, cy, radius, amount;
    logic [PIX_W-1:0] res;
    w = (vig_width > MAX_DIM) ? 64'(MAX_DIM) : 64'(vig_width);
    h = (vig_height > MAX_DIM) ? 64'(MAX_DIM) : 64'(vig_height);
    res = b.pix;
    if (b.col < w && b.row < h) begin
      // fold into the top-left quadrant
      qx = (w - 1 - b.col < b.col) ? w - 1 - b.col : 64'(b.col);
      qy = (h - 1 - b.row < b.row) ? h - 1 - b.row : 64'(b.row);
      cx = w >> 1;
      cy = h >> 1;
      // middle column and row of odd sizes pass
      if (qx < cx && qy < cy) begin
        radius = floor_root(((cx - qx) * (cx - qx) + (cy - qy) * (cy - qy))
                            << (2 * FRAC_BITS));
        if (radius >= vig_start) begin
          amount = ((radius - vig_start) * vig_gain) >> (FRAC_BITS + GAIN_FRAC);
          if (amount > 255) amount = 255;
          res = (amount > b.pix) ? '0 : b.pix - amount[PIX_W-1:0];
        end
      end
    end
    return res;
  endfunction

  // input driver: offers queued beats and holds each until it is taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else begin
      offering = in_chan.valid;
      if (in_chan.valid && in_chan.ready) begin
        expected_luma.push_back(darken_luma('{in_chan.pixel_in, in_chan.column,
                                              in_chan.row_index}));
        void'(pending_beats.pop_front());
        offering = 1'b0;
      end
      if (!offering) begin
        if (pending_beats.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_chan.valid     <= 1'b1;
          in_chan.pixel_in  <= pending_beats[0].pix;
          in_chan.column    <= pending_beats[0].col;
          in_chan.row_index <= pending_beats[0].row;
        end else begin
          in_chan.valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, counted here
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_cycles  <= 0;
      holds_served <= 0;
    end else if (holds_served != hold_requests) begin
      hold_cycles  <= HOLD_LEN;
      holds_served <= holds_served + 1;
    end else if (hold_cycles != 0) begin
      hold_cycles <= hold_cycles - 1;
    end
  end

  // output monitor: checks each result beat against the oldest expectation
  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        if (expected_luma.size() == 0) begin
          $display("%0t: pixel_out expected none, got %0d", $time, out_chan.pixel_out);
          mismatches++;
        end else begin
          want_luma = expected_luma.pop_front();
          if (out_chan.pixel_out !== want_luma) begin
            $display("%0t: pixel_out expected %0d, got %0d", $time, want_luma,
                     out_chan.pixel_out);
            mismatches++;
          end
        end
      end
      out_chan.ready <= (hold_cycles == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // register write, held until taken; updates the predictor copy
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= idx;
    cfg_chan.data  <= value;
    @(posedge clk);
    while (!cfg_chan.ready) @(posedge clk);
    case (idx)
      rvl_pkg::REG_IMAGE_WIDTH:  vig_width  = value[DIM_W-1:0];
      rvl_pkg::REG_IMAGE_HEIGHT: vig_height = value[DIM_W-1:0];
      rvl_pkg::REG_START_RADIUS: vig_start  = value[RAD_W-1:0];
      rvl_pkg::REG_RAMP_GAIN:    vig_gain   = value[GAIN_W-1:0];
      default: ;
    endcase
  endtask

  // full register set, sometimes after a write to an unmapped index, with junk in the unused upper data bits
  task automatic apply_settings(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                                input logic [RAD_W-1:0] st, input logic [GAIN_W-1:0] g);
    if ($urandom_range(0, 2) == 0) cfg_write(REG_UNMAPPED, $urandom());
    cfg_write(rvl_pkg::REG_IMAGE_WIDTH,  ($urandom() & 32'hFFFF_E000) | 32'(w));
    cfg_write(rvl_pkg::REG_IMAGE_HEIGHT, ($urandom() & 32'hFFFF_E000) | 32'(h));
    cfg_write(rvl_pkg::REG_START_RADIUS, ($urandom() & 32'hFFFF_0000) | 32'(st));
    cfg_write(rvl_pkg::REG_RAMP_GAIN,    ($urandom() & 32'hFF00_0000) | 32'(g));
    cfg_chan.valid <= 1'b0;
  endtask

  // wait until every queued beat is taken and every result has come back
  task automatic drain();
    while (pending_beats.size() != 0 || expected_luma.size() != 0) @(posedge clk);
  endtask

  task automatic queue_beat(input int pix, input int col, input int row);
    pending_beats.push_back('{PIX_W'(pix), POS_W'(col), POS_W'(row)});
  endtask

  function automatic logic [DIM_W-1:0] pick_dim();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return DIM_W'(1);
      2:       return DIM_W'(MAX_DIM);
      3:       return {DIM_W{1'b1}};
      4:       return DIM_W'($urandom_range(MAX_DIM + 1, 8191));
      5:       return DIM_W'($urandom_range(1, MAX_DIM));
      default: return DIM_W'($urandom_range(2, 40));
    endcase
  endfunction

  // position inside the frame most of the time
  function automatic int pick_pos(input int span);
    if (span != 0 && $urandom_range(0, 3) != 0) return $urandom_range(0, span - 1);
    return $urandom_range(0, 4095);
  endfunction

  // stimulus
  initial begin : stimulus
    logic [DIM_W-1:0]  w, h;
    logic [RAD_W-1:0]  st;
    logic [GAIN_W-1:0] g;
    int                fw, fh, n_beats;

    rst_n              = 1'b0;
    in_chan.valid      = 1'b0;
    in_chan.pixel_in   = '0;
    in_chan.column     = '0;
    in_chan.row_index  = '0;
    out_chan.ready     = 1'b0;
    cfg_chan.valid     = 1'b0;
    cfg_chan.index     = rvl_pkg::REG_IMAGE_WIDTH;
    cfg_chan.data      = '0;
    send_idle_pct      = 26;
    recv_idle_pct      = 60;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: 640 x 480, no darkening
    queue_beat(255, 0, 0);
    queue_beat(0, 639, 479);
    queue_beat(128, 4095, 4095);
    drain();

    // odd sizes, full gain: clamp, zero floor, middle column and row, outside
    apply_settings(7, 5, 16'h0010, 24'hFF_FFFF);
    queue_beat(200, 0, 0);
    queue_beat(255, 0, 0);
    queue_beat(255, 3, 1);
    queue_beat(255, 1, 2);
    queue_beat(100, 2, 1);
    queue_beat(77, 7, 0);
    queue_beat(77, 0, 5);
    queue_beat(255, 6, 4);
    drain();

    // oversized frame taken as the largest size
    apply_settings(13'h1FFF, 13'd5000, 16'h0000, 24'h00_1000);
    queue_beat(200, 4095, 0);
    queue_beat(200, 2048, 2048);
    queue_beat(17, 0, 4095);
    queue_beat(255, 100, 3000);
    drain();

    // zero width; start radius beyond any distance
    apply_settings(0, 1, 16'hFFFF, 24'hFF_FFFF);
    queue_beat(0, 0, 0);
    queue_beat(255, 4095, 0);
    drain();

    // single column and zero height
    apply_settings(1, 0, 16'h0000, 24'hFF_FFFF);
    queue_beat(255, 0, 0);
    queue_beat(255, 0, 4095);
    drain();

    // random settings and beats
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      drain();
      if (ph < 4) begin
        send_idle_pct = 26;
        recv_idle_pct = 60;
      end else if (ph < 7) begin
        send_idle_pct = 60;
        recv_idle_pct = 26;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      w  = pick_dim();
      h  = pick_dim();
      fw = (w > MAX_DIM) ? MAX_DIM : int'(w);
      fh = (h > MAX_DIM) ? MAX_DIM : int'(h);
      case ($urandom_range(0, 4))
        0:       st = '0;
        1:       st = '1;
        2:       st = RAD_W'($urandom());
        default: st = RAD_W'($urandom_range(0, 8 * (fw + fh)));
      endcase
      case ($urandom_range(0, 5))
        0:       g = '0;
        1:       g = '1;
        2:       g = GAIN_W'($urandom());
        default: g = GAIN_W'($urandom_range(0, 24'h0F_FFFF));
      endcase
      apply_settings(w, h, st, g);
      n_beats = (ph == HOLD_PHASE) ? 150 : $urandom_range(60, 80);
      // stall the results long enough for the block to back up its input
      if (ph == HOLD_PHASE) hold_requests <= hold_requests + 1;
      for (int i = 0; i < n_beats; i++)
        queue_beat($urandom_range(0, 255), pick_pos(fw), pick_pos(fh));
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_luma.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #3_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
